>>> rtl/lfu_page_replacement_defines.svh
// Assertion macros for the LFU page replacement block.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef LFU_PAGE_REPLACEMENT_DEFINES_SVH
`define LFU_PAGE_REPLACEMENT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Check an implication on every clock edge outside reset
`define LFU_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("lfu assertion failed");
// Check an implication that includes the cycle after the trigger
`define LFU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lfu assertion failed");
`else
`define LFU_ASSERT(lbl, clk, rst_n, prop)
`define LFU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/lfu_pkg.sv
// Shared types and constants for the LFU page replacement block.
// No dependencies.
package lfu_pkg;

    // Fixed field widths at the block boundary
    localparam int PAGE_IN_W  = 6;
    localparam int SLOT_OUT_W = 3;
    localparam int FIU_W      = 4;
    localparam int FAULT_W    = 16;
    localparam int APB_DW     = 32;
    localparam int APB_AW     = 3;

    // Register index of frames_in_use and its reset value
    localparam logic REG_FRAMES_IN_USE = 1'b0;
    localparam logic [FIU_W-1:0] FIU_RESET = 4'd3;

    // Status of the frame scan unit
    typedef struct packed {
        logic busy;
        logic hit_found;
        logic empty_found;
    } t_scan_flags;

endpackage

>>> rtl/lfu_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module lfu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and read one entry per cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/lfu_scan.sv
// Frame scan unit: walks the active frames one per cycle, finds a hit,
// the first empty frame and the least-used page. Uses lfu_pkg.
module lfu_scan #(
    parameter int FW = 3,
    parameter int PW = 6,
    parameter int CW = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_clr,
    input  logic                 i_issue,
    input  logic [FW-1:0]        i_issue_idx,
    input  logic                 i_issue_fvalid,
    input  logic [PW-1:0]        i_page,
    input  logic [PW-1:0]        i_fpage,
    input  logic [CW-1:0]        i_count,
    output logic [PW-1:0]        o_cnt_raddr,
    output lfu_pkg::t_scan_flags o_flags,
    output logic [FW-1:0]        o_hit_slot,
    output logic [FW-1:0]        o_empty_slot,
    output logic [FW-1:0]        o_min_slot,
    output logic [PW-1:0]        o_min_page
);

    logic          r_s1_v, r_s1_fv, r_s2_v;
    logic [FW-1:0] r_s1_idx, r_s2_idx;
    logic [PW-1:0] r_s2_page;
    logic          r_hit, r_emp, r_min_have;
    logic [FW-1:0] r_hit_slot, r_emp_slot, r_min_slot;
    logic [CW-1:0] r_min_cnt;
    logic [PW-1:0] r_min_page;

    // Stage control: frame read returns in stage 1, count read in stage 2
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_s1_v     <= 1'b0;
            r_s2_v     <= 1'b0;
            r_hit      <= 1'b0;
            r_emp      <= 1'b0;
            r_min_have <= 1'b0;
        end else begin
            r_s1_v <= i_issue;
            r_s2_v <= r_s1_v;
            if (r_s1_v && r_s1_fv && (i_fpage == i_page) && !r_hit) begin
                r_hit <= 1'b1;
            end
            if (r_s1_v && !r_s1_fv && !r_emp) begin
                r_emp <= 1'b1;
            end
            if (r_s2_v) begin
                r_min_have <= 1'b1;
            end
        end
    end

    // Stage payload and running results
    always_ff @(posedge i_clk) begin
        r_s1_idx  <= i_issue_idx;
        r_s1_fv   <= i_issue_fvalid;
        r_s2_idx  <= r_s1_idx;
        r_s2_page <= i_fpage;
        if (r_s1_v && r_s1_fv && (i_fpage == i_page) && !r_hit) begin
            r_hit_slot <= r_s1_idx;
        end
        if (r_s1_v && !r_s1_fv && !r_emp) begin
            r_emp_slot <= r_s1_idx;
        end
        // Strict less keeps the lowest index on ties
        if (r_s2_v && (!r_min_have || (i_count < r_min_cnt))) begin
            r_min_cnt  <= i_count;
            r_min_slot <= r_s2_idx;
            r_min_page <= r_s2_page;
        end
    end

    assign o_cnt_raddr         = i_fpage;
    assign o_flags.busy        = r_s1_v | r_s2_v;
    assign o_flags.hit_found   = r_hit;
    assign o_flags.empty_found = r_emp;
    assign o_hit_slot          = r_hit_slot;
    assign o_empty_slot        = r_emp_slot;
    assign o_min_slot          = r_min_slot;
    assign o_min_page          = r_min_page;

endmodule

>>> rtl/lfu_page_replacement.sv
// LFU page replacement: an accepted page is reduced into range by repeated subtraction of
// PAGES, then the frame scan issues one frame read per cycle over the active frames, the
// slot is decided, and the use count is written back when the output register is free.
// A new page is taken once the previous one has left the sequencer.
// After reset the use-count memory is cleared entry by entry with input stalled.
// Uses lfu_pkg, lfu_ram, lfu_scan and lfu_page_replacement_defines.svh.
`include "lfu_page_replacement_defines.svh"

module lfu_page_replacement #(
    parameter int FRAMES     = 8,
    parameter int PAGES      = 64,
    parameter int COUNT_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [lfu_pkg::PAGE_IN_W-1:0]    i_page_number,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_hit,
    output logic [lfu_pkg::SLOT_OUT_W-1:0]   o_frame_slot,
    output logic                             o_evicted_valid,
    output logic [lfu_pkg::PAGE_IN_W-1:0]    o_evicted_page,
    output logic [lfu_pkg::FAULT_W-1:0]      o_fault_count,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [lfu_pkg::APB_AW-1:0]       paddr,
    input  logic [lfu_pkg::APB_DW-1:0]       pwdata,
    output logic [lfu_pkg::APB_DW-1:0]       prdata,
    output logic                             pready
);

    localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int NW = $clog2(FRAMES + 1);
    localparam int PW = $clog2(PAGES);
    localparam int CW = COUNT_BITS;

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_REDUCE = 6'b000100,
        S_SCAN   = 6'b001000,
        S_DECIDE = 6'b010000,
        S_CNT_WB = 6'b100000
    } t_state;

    t_state                         r_state, n_state;
    logic [PW-1:0]                  r_clr_idx;
    logic [lfu_pkg::PAGE_IN_W-1:0]  r_page;
    logic [NW-1:0]                  r_rd_idx;
    logic [FRAMES-1:0]              r_fvalid;
    logic [lfu_pkg::FIU_W-1:0]      r_fiu;
    logic [lfu_pkg::FAULT_W-1:0]    r_fault;
    logic [FW-1:0]                  r_slot;
    logic                           r_hit, r_evict;
    logic [lfu_pkg::PAGE_IN_W-1:0]  r_evpage;
    logic                           r_out_valid;
    logic                           r_o_hit, r_o_evict;
    logic [lfu_pkg::SLOT_OUT_W-1:0] r_o_slot;
    logic [lfu_pkg::PAGE_IN_W-1:0]  r_o_evpage;
    logic [lfu_pkg::FAULT_W-1:0]    r_o_fault;

    logic [PW-1:0]        w_page;
    logic [NW-1:0]        w_nact;
    logic                 w_issue, w_scan_done, w_out_free, w_load;
    logic [PW-1:0]        w_fpage, w_scan_craddr, w_min_page;
    logic [CW-1:0]        w_count, w_count_inc;
    logic [FW-1:0]        w_hit_slot, w_empty_slot, w_min_slot, w_dec_slot;
    lfu_pkg::t_scan_flags w_flags;
    logic                 w_frame_we, w_cnt_we;
    logic [PW-1:0]        w_cnt_waddr, w_cnt_raddr;
    logic [CW-1:0]        w_cnt_wdata;
    logic                 w_cfg_wr;

    // Configuration register write and read-back
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == lfu_pkg::REG_FRAMES_IN_USE);
    assign prdata   = (paddr[2] == lfu_pkg::REG_FRAMES_IN_USE) ?
                      lfu_pkg::APB_DW'(r_fiu) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fiu <= lfu_pkg::FIU_RESET;
        end else if (w_cfg_wr) begin
            r_fiu <= pwdata[lfu_pkg::FIU_W-1:0];
        end
    end

    // Clamp the active frame count to 1..FRAMES
    always_comb begin
        if (r_fiu == '0) begin
            w_nact = NW'(1);
        end else if (int'(r_fiu) > FRAMES) begin
            w_nact = NW'(FRAMES);
        end else begin
            w_nact = NW'(r_fiu);
        end
    end

    assign w_page      = PW'(r_page);
    assign w_issue     = (r_state == S_SCAN) && (r_rd_idx < w_nact);
    assign w_scan_done = (r_state == S_SCAN) && !w_issue && !w_flags.busy;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_load      = (r_state == S_CNT_WB) && w_out_free;
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_count_inc = (w_count == '1) ? w_count : w_count + CW'(1);

    // Slot choice: hit, else first empty frame, else least-used page
    always_comb begin
        priority if (w_flags.hit_found) begin
            w_dec_slot = w_hit_slot;
        end else if (w_flags.empty_found) begin
            w_dec_slot = w_empty_slot;
        end else begin
            w_dec_slot = w_min_slot;
        end
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:  if (r_clr_idx == PW'(PAGES - 1)) n_state = S_IDLE;
            S_IDLE:   if (i_in_valid) n_state = S_REDUCE;
            S_REDUCE: if (int'(r_page) < PAGES) n_state = S_SCAN;
            S_SCAN:   if (w_scan_done) n_state = S_DECIDE;
            S_DECIDE: n_state = S_CNT_WB;
            S_CNT_WB: if (w_out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_idx <= '0;
            r_fvalid  <= '0;
            r_fault   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_idx <= r_clr_idx + PW'(1);
            end
            // Fill the chosen frame and count the fault on a miss
            if ((r_state == S_DECIDE) && !w_flags.hit_found) begin
                r_fvalid[w_dec_slot] <= 1'b1;
                if (r_fault != '1) begin
                    r_fault <= r_fault + lfu_pkg::FAULT_W'(1);
                end
            end
        end
    end

    // Page capture, modulo reduction and scan index
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_in_valid) begin
            r_page <= i_page_number;
        end else if ((r_state == S_REDUCE) && (int'(r_page) >= PAGES)) begin
            r_page <= r_page - lfu_pkg::PAGE_IN_W'(PAGES);
        end
        if (r_state == S_REDUCE) begin
            r_rd_idx <= '0;
        end else if (w_issue) begin
            r_rd_idx <= r_rd_idx + NW'(1);
        end
        if (r_state == S_DECIDE) begin
            r_slot   <= w_dec_slot;
            r_hit    <= w_flags.hit_found;
            r_evict  <= !w_flags.hit_found && !w_flags.empty_found;
            r_evpage <= (!w_flags.hit_found && !w_flags.empty_found) ?
                        lfu_pkg::PAGE_IN_W'(w_min_page) : '0;
        end
    end

    // Output register: load a finished transaction, drop it when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_o_hit    <= r_hit;
            r_o_slot   <= lfu_pkg::SLOT_OUT_W'(r_slot);
            r_o_evict  <= r_evict;
            r_o_evpage <= r_evpage;
            r_o_fault  <= r_fault;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_hit           = r_o_hit;
    assign o_frame_slot    = r_o_slot;
    assign o_evicted_valid = r_o_evict;
    assign o_evicted_page  = r_o_evpage;
    assign o_fault_count   = r_o_fault;

    // Frame page store
    assign w_frame_we = (r_state == S_DECIDE) && !w_flags.hit_found;

    lfu_ram #(
        .WIDTH (PW),
        .DEPTH (FRAMES)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (w_frame_we),
        .i_waddr (w_dec_slot),
        .i_wdata (w_page),
        .i_raddr (r_rd_idx[FW-1:0]),
        .o_rdata (w_fpage)
    );

    // Use-count store: cleared after reset, read during scan and update
    assign w_cnt_we    = (r_state == S_CLEAR) || w_load;
    assign w_cnt_waddr = (r_state == S_CLEAR) ? r_clr_idx : w_page;
    assign w_cnt_wdata = (r_state == S_CLEAR) ? '0 : w_count_inc;
    assign w_cnt_raddr = ((r_state == S_DECIDE) || (r_state == S_CNT_WB)) ?
                         w_page : w_scan_craddr;

    lfu_ram #(
        .WIDTH (CW),
        .DEPTH (PAGES)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (w_cnt_we),
        .i_waddr (w_cnt_waddr),
        .i_wdata (w_cnt_wdata),
        .i_raddr (w_cnt_raddr),
        .o_rdata (w_count)
    );

    lfu_scan #(
        .FW (FW),
        .PW (PW),
        .CW (CW)
    ) u_scan (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_clr          (r_state == S_REDUCE),
        .i_issue        (w_issue),
        .i_issue_idx    (r_rd_idx[FW-1:0]),
        .i_issue_fvalid (r_fvalid[r_rd_idx[FW-1:0]]),
        .i_page         (w_page),
        .i_fpage        (w_fpage),
        .i_count        (w_count),
        .o_cnt_raddr    (w_scan_craddr),
        .o_flags        (w_flags),
        .o_hit_slot     (w_hit_slot),
        .o_empty_slot   (w_empty_slot),
        .o_min_slot     (w_min_slot),
        .o_min_page     (w_min_page)
    );

    // A hit never evicts, and a result without eviction reports page zero
    `LFU_ASSERT(a_hit_no_evict, i_clk, i_rst_n, o_out_valid |-> !(o_hit && o_evicted_valid))
    `LFU_ASSERT(a_no_evict_zero, i_clk, i_rst_n, (o_out_valid && !o_evicted_valid) |-> (o_evicted_page == '0))
    // The chosen slot lies within the active frames
    `LFU_ASSERT(a_slot_active, i_clk, i_rst_n, (r_state == S_CNT_WB) |-> (int'(r_slot) < int'(w_nact)))
    // A miss leaves its slot marked valid
    `LFU_ASSERT_NEXT(a_fill_valid, i_clk, i_rst_n, (r_state == S_DECIDE) && !w_flags.hit_found, r_fvalid[r_slot])

endmodule

>>> test/lfu_checker.sv
// Scoreboard for the LFU page replacement block: tracks frames, use counts and the
// frame-count register from the bus traffic, and checks every result transaction.
// Depends on lfu_pkg for field widths and the register index.
module lfu_checker
    import lfu_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_stall,
    input  logic [PAGE_IN_W-1:0]   i_page_number,
    input  logic                   i_out_valid,
    input  logic                   i_out_stall,
    input  logic                   i_hit,
    input  logic [SLOT_OUT_W-1:0]  i_frame_slot,
    input  logic                   i_evicted_valid,
    input  logic [PAGE_IN_W-1:0]   i_evicted_page,
    input  logic [FAULT_W-1:0]     i_fault_count,
    input  logic                   i_psel,
    input  logic                   i_penable,
    input  logic                   i_pwrite,
    input  logic [APB_AW-1:0]      i_paddr,
    input  logic [APB_DW-1:0]      i_pwdata,
    input  logic                   i_pready,
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_checked,
    output int                     o_hits,
    output int                     o_evictions
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_FRAMES = 8;
    localparam int NUM_PAGES  = 64;
    localparam logic [15:0] COUNT_CEIL = 16'hFFFF;
    localparam logic [FAULT_W-1:0] FAULT_CEIL = '1;
    localparam logic [APB_AW-1:0] FIU_ADDR = {REG_FRAMES_IN_USE, 2'b00};
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic                  hit;
        logic [SLOT_OUT_W-1:0] slot;
        logic                  evicted;
        logic [PAGE_IN_W-1:0]  victim;
        logic [FAULT_W-1:0]    faults;
    } t_page_outcome;

    // Shadow of the replacement state
    logic [PAGE_IN_W-1:0] frame_pg   [NUM_FRAMES];
    logic                 frame_full [NUM_FRAMES];
    logic [15:0]          ref_cnt    [NUM_PAGES];
    logic [FAULT_W-1:0]   faults;
    logic [FIU_W-1:0]     frame_limit;

    t_page_outcome page_outcomes_q [$];
    int fails;
    int checked;
    int hits;
    int evictions;

    // Resolve one page reference against the shadow state and update it
    function automatic t_page_outcome lfu_access(input logic [PAGE_IN_W-1:0] pg);
        int n;
        int i;
        int slot;
        bit hit;
        bit got_empty;
        logic [15:0] best;
        t_page_outcome r;
        n = (frame_limit == 0) ? 1 : ((frame_limit > NUM_FRAMES) ? NUM_FRAMES : frame_limit);
        slot = 0;
        hit = 1'b0;
        got_empty = 1'b0;
        r = '0;
        // lowest active frame holding the page wins
        for (i = 0; i < n; i++) begin
            if (!hit && frame_full[i] && frame_pg[i] == pg) begin
                hit = 1'b1;
                slot = i;
            end
        end
        if (!hit) begin
            for (i = 0; i < n; i++) begin
                if (!got_empty && !frame_full[i]) begin
                    got_empty = 1'b1;
                    slot = i;
                end
            end
            // no empty frame: replace the least used page, ties to the lowest index
            if (!got_empty) begin
                best = ref_cnt[frame_pg[0]];
                slot = 0;
                for (i = 1; i < n; i++) begin
                    if (ref_cnt[frame_pg[i]] < best) begin
                        best = ref_cnt[frame_pg[i]];
                        slot = i;
                    end
                end
                r.evicted = 1'b1;
                r.victim = frame_pg[slot];
            end
            frame_pg[slot] = pg;
            frame_full[slot] = 1'b1;
            if (faults != FAULT_CEIL) faults = faults + 1'b1;
        end
        if (ref_cnt[pg] != COUNT_CEIL) ref_cnt[pg] = ref_cnt[pg] + 1'b1;
        r.hit = hit;
        r.slot = slot[SLOT_OUT_W-1:0];
        r.faults = faults;
        return r;
    endfunction

    always @(posedge i_clk) begin : watch_channels
        t_page_outcome got;
        t_page_outcome want;
        int i;
        if (!i_rst_n) begin
            for (i = 0; i < NUM_FRAMES; i++) begin
                frame_pg[i] = '0;
                frame_full[i] = 1'b0;
            end
            for (i = 0; i < NUM_PAGES; i++) ref_cnt[i] = '0;
            faults = '0;
            frame_limit = FIU_RESET;
            page_outcomes_q.delete();
            fails = 0;
            checked = 0;
            hits = 0;
            evictions = 0;
        end else begin
            // track register writes
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == FIU_ADDR) begin
                frame_limit = i_pwdata[FIU_W-1:0];
            end
            // check a result transaction against the oldest prediction
            if (i_out_valid && !i_out_stall) begin
                got = '{i_hit, i_frame_slot, i_evicted_valid, i_evicted_page, i_fault_count};
                if (page_outcomes_q.size() == 0) begin
                    fails++;
                    if (fails <= REPORT_LIMIT) begin
                        $display("[%0t] result with nothing outstanding: hit=%0b slot=%0d",
                                 $realtime, got.hit, got.slot);
                    end
                end else begin
                    want = page_outcomes_q.pop_front();
                    checked++;
                    if (want.hit) hits++;
                    if (want.evicted) evictions++;
                    if (got.hit !== want.hit || got.slot !== want.slot ||
                        got.evicted !== want.evicted || got.victim !== want.victim ||
                        got.faults !== want.faults) begin
                        fails++;
                        if (fails <= REPORT_LIMIT) begin
                            $display("[%0t] result %0d: expected hit=%0b slot=%0d ev=%0b/%0d faults=%0d",
                                     $realtime, checked, want.hit, want.slot, want.evicted,
                                     want.victim, want.faults);
                            $display("           actual   hit=%0b slot=%0d ev=%0b/%0d faults=%0d",
                                     got.hit, got.slot, got.evicted, got.victim, got.faults);
                        end
                    end
                end
            end
            // predict each accepted page reference
            if (i_in_valid && !i_in_stall) begin
                page_outcomes_q.push_back(lfu_access(i_page_number));
            end
        end
        o_fail_count <= fails;
        o_pending <= page_outcomes_q.size();
        o_checked <= checked;
        o_hits <= hits;
        o_evictions <= evictions;
    end

endmodule

>>> test/tb_top.sv
// Top of the LFU page replacement testbench: clock, reset, page and register stimulus,
// verdict. Depends on lfu_pkg, the lfu_page_replacement RTL and lfu_checker.
module tb_top;
    import lfu_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_FRAMES = 8;
    localparam int SEGMENTS = 12;
    localparam int SEG_ITEMS = 112;
    localparam logic [APB_AW-1:0] FIU_ADDR = {REG_FRAMES_IN_USE, 2'b00};

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic [PAGE_IN_W-1:0]  page_number = '0;
    logic                  out_stall = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_AW-1:0]     paddr = '0;
    logic [APB_DW-1:0]     pwdata = '0;

    logic                  in_stall;
    logic                  out_valid;
    logic                  hit;
    logic [SLOT_OUT_W-1:0] frame_slot;
    logic                  evicted_valid;
    logic [PAGE_IN_W-1:0]  evicted_page;
    logic [FAULT_W-1:0]    fault_count;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;

    int fail_count;
    int pending;
    int checked;
    int hits;
    int evictions;

    int send_idle_pct = 0;
    int stall_pct = 0;
    int sent = 0;

    // frame-count settings per random segment, extremes and out-of-range values included
    logic [FIU_W-1:0] frame_plan [SEGMENTS] = '{4'd8, 4'd1, 4'd15, 4'd4, 4'd0, 4'd6,
                                                4'd2, 4'd9, 4'd7, 4'd3, 4'd5, 4'd8};

    lfu_page_replacement u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_page_number   (page_number),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_hit           (hit),
        .o_frame_slot    (frame_slot),
        .o_evicted_valid (evicted_valid),
        .o_evicted_page  (evicted_page),
        .o_fault_count   (fault_count),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    lfu_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_page_number   (page_number),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_hit           (hit),
        .i_frame_slot    (frame_slot),
        .i_evicted_valid (evicted_valid),
        .i_evicted_page  (evicted_page),
        .i_fault_count   (fault_count),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .i_pready        (pready),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked       (checked),
        .o_hits          (hits),
        .o_evictions     (evictions)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Stall the result channel at random when the phase asks for it
    always @(negedge i_clk) begin
        out_stall = (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
    end

    // Offer one page reference and hold it until the transaction is taken
    task automatic send_page(input logic [PAGE_IN_W-1:0] pg);
        @(negedge i_clk);
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            in_valid = 1'b0;
            @(negedge i_clk);
        end
        in_valid = 1'b1;
        page_number = pg;
        do @(posedge i_clk); while (in_stall);
        sent++;
    endtask

    // Drain all outstanding results, then write the frame count over the register port
    task automatic set_frames(input logic [FIU_W-1:0] value);
        @(negedge i_clk);
        in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = FIU_ADDR;
        pwdata = $urandom();
        pwdata[FIU_W-1:0] = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    initial begin
        int seg;
        int k;
        int active;
        int span;
        int hot;
        logic [PAGE_IN_W-1:0] pool_base;
        logic [PAGE_IN_W-1:0] pg;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Fill from empty (page zero must not hit an empty frame), hit, then evict on ties
        send_page(6'd0);
        send_page(6'd63);
        send_page(6'd0);
        send_page(6'd21);
        send_page(6'd42);
        send_page(6'd63);

        // Single frame: frame 0 takes a page already parked in an inactive frame
        set_frames(4'd1);
        send_page(6'd21);
        // Too many frames: acts as eight; duplicate resident page hits the lowest index
        set_frames(4'd15);
        send_page(6'd21);
        for (k = 10; k < 15; k++) send_page(k[PAGE_IN_W-1:0]);
        send_page(6'd50);
        send_page(6'd10);
        // Zero frames acts as one
        set_frames(4'd0);
        send_page(6'd5);
        send_page(6'd5);
        send_page(6'd63);
        // Just above the frame count
        set_frames(4'd9);
        send_page(6'd33);
        send_page(6'd7);

        // Random segments: a working set with a hot subset, plus noise over all pages
        for (seg = 0; seg < SEGMENTS; seg++) begin
            set_frames(frame_plan[seg]);
            case (seg % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 85; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 85; end
                default: begin send_idle_pct = 38; stall_pct = 38; end
            endcase
            active = (frame_plan[seg] == 0) ? 1 :
                     ((frame_plan[seg] > NUM_FRAMES) ? NUM_FRAMES : frame_plan[seg]);
            pool_base = PAGE_IN_W'($urandom_range(0, 63));
            span = active + $urandom_range(1, 4);
            hot = active / 2 + 1;
            for (k = 0; k < SEG_ITEMS; k++) begin
                if ($urandom_range(0, 99) < 85) begin
                    pg = PAGE_IN_W'(pool_base +
                         $urandom_range(0, $urandom_range(0, 1) ? hot - 1 : span - 1));
                end else begin
                    pg = PAGE_IN_W'($urandom_range(0, 63));
                end
                send_page(pg);
            end
        end

        // Closing burst over all eight frames with random pages
        set_frames(4'd8);
        send_idle_pct = 38;
        stall_pct = 38;
        for (k = 0; k < 16; k++) send_page(PAGE_IN_W'($urandom_range(0, 63)));

        // Drop valid, drain, and let the pipeline settle
        @(negedge i_clk);
        in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);

        $display("Summary: %0d page references sent, %0d results checked (%0d hits, %0d evictions),",
                 sent, checked, hits, evictions);
        $display("         frame counts from zero to fifteen, idle senders and stalled receivers");
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("Timeout with %0d results outstanding", pending);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
